// ===== rtl/lprt_pkg.sv =====
package lprt_pkg;

    localparam int unsigned TableEntries = 64;

    localparam logic [2:0] MODE_LOOKUP   = 3'd0;
    localparam logic [2:0] MODE_ADD      = 3'd1;
    localparam logic [2:0] MODE_DEL_DEST = 3'd2;
    localparam logic [2:0] MODE_DEL_GW   = 3'd3;
    localparam logic [2:0] MODE_DEL_EXACT = 3'd4;
    localparam logic [2:0] MODE_CLEAR    = 3'd5;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_BAD_PREFIX  = 3'd1;
    localparam logic [2:0] ST_BAD_ADDRESS = 3'd2;
    localparam logic [2:0] ST_BAD_GATEWAY = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND   = 3'd4;
    localparam logic [2:0] ST_FULL        = 3'd5;

    localparam logic REG_MIN_PREFIX = 1'b0;
    localparam logic REG_MAX_PREFIX = 1'b1;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] address;
        logic [5:0]  prefix_len;
        logic [31:0] gateway;
    } t_op;

    typedef struct packed {
        logic [2:0]  status;
        logic        hit;
        logic [31:0] next_hop;
        logic [6:0]  removed_count;
    } t_result;

    // Running scan state handed from cell to cell.
    typedef struct packed {
        logic        best_hit;
        logic [5:0]  best_len;
        logic [31:0] best_hop;
        logic        same_found;
        logic        free_found;
        logic [6:0]  removed;
    } t_scan;

    function automatic logic [31:0] net_mask(input logic [5:0] p);
        logic [31:0] m;
        begin
            if (p == 6'd0) begin
                m = 32'd0;
            end else if (p >= 6'd32) begin
                m = '1;
            end else begin
                m = ~(32'hFFFF_FFFF >> p);
            end
            return m;
        end
    endfunction

endpackage

// ===== rtl/lprt_if.sv =====
interface lprt_op_if;
    logic              valid;
    logic              ready;
    lprt_pkg::t_op     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface lprt_res_if;
    logic              valid;
    logic              ready;
    lprt_pkg::t_result data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface lprt_cfg_if;
    logic       valid;
    logic       ready;
    logic       index;
    logic [5:0] wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ===== rtl/lprt_cell.sv =====
// One route slot. A token with the operation passes through the row, one cell
// per cycle; each cell folds its entry into the scan state and hands it on.
module lprt_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_tok,
    input  lprt_pkg::t_op    i_op,
    input  lprt_pkg::t_scan  i_scan,
    input  logic             i_commit,
    input  logic             i_write,
    input  logic             i_clear,
    output logic             o_tok,
    output lprt_pkg::t_op    o_op,
    output lprt_pkg::t_scan  o_scan
);
    logic        r_valid;
    logic [31:0] r_dest;
    logic [5:0]  r_prefix;
    logic [31:0] r_gw;
    logic        r_tok;
    logic        r_del;
    logic        r_same;
    logic        r_first;
    lprt_pkg::t_op   r_op;
    lprt_pkg::t_scan r_scan;
    lprt_pkg::t_scan n_scan;
    logic        n_del;
    logic        n_same;
    logic        n_first;
    logic        dest_eq;

    always_comb begin
        n_scan  = i_scan;
        n_del   = 1'b0;
        n_same  = 1'b0;
        n_first = 1'b0;
        dest_eq = r_valid && (r_dest == i_op.address);
        case (i_op.mode)
            lprt_pkg::MODE_LOOKUP: begin
                // i_op.prefix_len carries the length under test
                if (r_valid && r_prefix <= i_op.prefix_len &&
                    r_dest == (i_op.address & lprt_pkg::net_mask(i_op.prefix_len)) &&
                    (!i_scan.best_hit || r_prefix > i_scan.best_len)) begin
                    n_scan.best_hit = 1'b1;
                    n_scan.best_len = r_prefix;
                    n_scan.best_hop = r_gw;
                end
            end
            lprt_pkg::MODE_ADD: begin
                if (dest_eq && r_prefix == i_op.prefix_len && !i_scan.same_found) begin
                    n_scan.same_found = 1'b1;
                    n_same = 1'b1;
                end
                // the first free slot along the row takes a new route
                if (!r_valid) begin
                    n_scan.free_found = 1'b1;
                    n_first = !i_scan.free_found;
                end
            end
            lprt_pkg::MODE_DEL_DEST, lprt_pkg::MODE_DEL_GW, lprt_pkg::MODE_DEL_EXACT: begin
                if (dest_eq &&
                    (i_op.mode == lprt_pkg::MODE_DEL_DEST || r_gw == i_op.gateway) &&
                    (i_op.mode != lprt_pkg::MODE_DEL_EXACT || r_prefix == i_op.prefix_len)) begin
                    n_del = 1'b1;
                    n_scan.removed = i_scan.removed + 7'd1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= 1'b0;
        end else begin
            r_tok <= i_tok;
        end
        if (i_tok) begin
            r_op    <= i_op;
            r_scan  <= n_scan;
            r_del   <= n_del;
            r_same  <= n_same;
            r_first <= n_first;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_clear) begin
            r_valid <= 1'b0;
        end else if (i_commit && r_del) begin
            r_valid <= 1'b0;
        end else if (i_write && r_first) begin
            r_valid <= 1'b1;
        end
        if (i_write && r_first) begin
            r_dest   <= i_op.address;
            r_prefix <= i_op.prefix_len;
            r_gw     <= i_op.gateway;
        end else if (i_commit && r_same) begin
            r_gw <= i_op.gateway;
        end
    end

    assign o_tok  = r_tok;
    assign o_op   = r_op;
    assign o_scan = r_scan;
endmodule

// ===== rtl/longest_prefix_route_table_unit.sv =====
// Channel  | dir | handshake     | payload
// i_op     | in  | valid / ready | mode, address, prefix_len, gateway
// o_res    | out | valid / ready | status, hit, next_hop, removed_count
// i_cfg    | in  | valid / ready | index, wdata (min_prefix, max_prefix)
//
// One operation at a time. Non-lookup: one pass of the token along the cell
// row. Lookup: one pass per searched prefix length, longest first, stopping at
// the first hit or after the minimum prefix length. The cell row is the limit.
// Reset clears all valid bits at once.
// A stalled result holds in the output register; the next operation is taken
// once the result is transferred.
module longest_prefix_route_table_unit #(
    parameter int unsigned TABLE_ENTRIES = lprt_pkg::TableEntries
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lprt_op_if.sink   i_op,
    lprt_res_if.source o_res,
    lprt_cfg_if.sink  i_cfg
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]  r_state;
    logic [5:0]  r_min, r_max;
    lprt_pkg::t_op r_op;
    logic [5:0]  r_plen;        // current lookup length
    logic [5:0]  r_lo;
    logic        r_launch;
    lprt_pkg::t_result r_res;
    lprt_pkg::t_scan   r_fin;

    logic [TABLE_ENTRIES:0] tok;
    lprt_pkg::t_op   op_c [TABLE_ENTRIES+1];
    lprt_pkg::t_scan scan_c [TABLE_ENTRIES+1];
    logic        commit;
    logic        clear;
    logic        do_write;
    logic [5:0]  hi;
    logic [2:0]  chk;

    assign i_cfg.ready = 1'b1;
    assign i_op.ready  = (r_state == S_IDLE);
    assign o_res.valid = (r_state == S_OUT);
    assign o_res.data  = r_res;

    assign hi = (r_max > 6'd32) ? 6'd32 : r_max;

    // Add operand checks, in priority order.
    always_comb begin
        if (r_op.prefix_len > 6'd32 || r_op.prefix_len < r_min || r_op.prefix_len > r_max)
            chk = lprt_pkg::ST_BAD_PREFIX;
        else if (r_op.address == '1)
            chk = lprt_pkg::ST_BAD_ADDRESS;
        else if (r_op.gateway == '0 || r_op.gateway == '1)
            chk = lprt_pkg::ST_BAD_GATEWAY;
        else if ((r_op.address & lprt_pkg::net_mask(r_op.prefix_len)) != r_op.address)
            chk = lprt_pkg::ST_BAD_ADDRESS;
        else
            chk = lprt_pkg::ST_OK;
    end

    assign tok[0]    = r_launch;
    assign op_c[0]   = (r_op.mode == lprt_pkg::MODE_LOOKUP) ?
                       '{mode: r_op.mode, address: r_op.address, prefix_len: r_plen,
                         gateway: r_op.gateway} : r_op;
    assign scan_c[0] = '0;

    // Commit at the end of a pass: deletes and gateway rewrites all at once.
    assign commit   = (r_state == S_DONE) &&
                      (((r_op.mode == lprt_pkg::MODE_ADD) && chk == lprt_pkg::ST_OK) ||
                       r_op.mode == lprt_pkg::MODE_DEL_DEST ||
                       r_op.mode == lprt_pkg::MODE_DEL_GW ||
                       r_op.mode == lprt_pkg::MODE_DEL_EXACT);
    assign clear    = (r_state == S_DONE) && (r_op.mode == lprt_pkg::MODE_CLEAR);
    // The cell that saw the first free slot on the pass takes the new route.
    assign do_write = (r_state == S_DONE) && (r_op.mode == lprt_pkg::MODE_ADD) &&
                      chk == lprt_pkg::ST_OK && !r_fin.same_found && r_fin.free_found;

    genvar g;
    generate
        for (g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
            lprt_cell u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_tok    (tok[g]),
                .i_op     (op_c[g]),
                .i_scan   (scan_c[g]),
                .i_commit (commit && r_op.mode != lprt_pkg::MODE_ADD ? 1'b1 :
                           (commit && !do_write)),
                .i_write  (do_write),
                .i_clear  (clear),
                .o_tok    (tok[g+1]),
                .o_op     (op_c[g+1]),
                .o_scan   (scan_c[g+1])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= 6'd0;
            r_max <= 6'd32;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == lprt_pkg::REG_MIN_PREFIX) r_min <= i_cfg.wdata;
            else r_max <= i_cfg.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_launch <= 1'b0;
        end else begin
            r_launch <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_op.valid) begin
                        r_op    <= i_op.data;
                        r_plen  <= hi;
                        r_lo    <= r_min;
                        r_state <= S_RUN;
                        // a lookup with an empty search range skips the row
                        r_launch <= !(i_op.data.mode == lprt_pkg::MODE_LOOKUP &&
                                      r_min > hi);
                        if (i_op.data.mode == lprt_pkg::MODE_LOOKUP && r_min > hi) begin
                            r_fin   <= '0;
                            r_state <= S_DONE;
                        end
                    end
                end
                S_RUN: begin
                    if (tok[TABLE_ENTRIES]) begin
                        if (r_op.mode == lprt_pkg::MODE_LOOKUP &&
                            !scan_c[TABLE_ENTRIES].best_hit && r_plen > r_lo) begin
                            r_plen   <= r_plen - 6'd1;
                            r_launch <= 1'b1;
                        end else begin
                            r_fin   <= scan_c[TABLE_ENTRIES];
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    r_res.status        <= lprt_pkg::ST_OK;
                    r_res.hit           <= 1'b0;
                    r_res.next_hop      <= '1;
                    r_res.removed_count <= 7'd0;
                    case (r_op.mode)
                        lprt_pkg::MODE_LOOKUP: begin
                            r_res.hit <= r_fin.best_hit;
                            if (r_fin.best_hit) r_res.next_hop <= r_fin.best_hop;
                        end
                        lprt_pkg::MODE_ADD: begin
                            if (chk != lprt_pkg::ST_OK) r_res.status <= chk;
                            else if (!r_fin.same_found && !r_fin.free_found)
                                r_res.status <= lprt_pkg::ST_FULL;
                        end
                        lprt_pkg::MODE_DEL_DEST, lprt_pkg::MODE_DEL_GW,
                        lprt_pkg::MODE_DEL_EXACT: begin
                            r_res.removed_count <= r_fin.removed;
                            if (r_fin.removed == 7'd0) r_res.status <= lprt_pkg::ST_NOT_FOUND;
                        end
                        default: begin
                        end
                    endcase
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (o_res.ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== rtl/lprt_checker.sv =====
module lprt_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              op_valid,
    input logic              op_ready,
    input logic              res_valid,
    input logic              res_ready,
    input lprt_pkg::t_result res
);
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> !op_ready) else $error("op taken with result pending");
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        op_valid && op_ready |=> !op_ready) else $error("second op taken");
    a_hit_hop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid && !res.hit |-> res.next_hop == 32'hFFFF_FFFF) else $error("miss hop");
    a_hit_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid && res.hit |-> res.status == lprt_pkg::ST_OK &&
        res.removed_count == 7'd0) else $error("hit fields");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res)) else $error("result dropped");
endmodule

bind longest_prefix_route_table_unit lprt_checker u_lprt_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .op_valid  (i_op.valid),
    .op_ready  (i_op.ready),
    .res_valid (o_res.valid),
    .res_ready (o_res.ready),
    .res       (o_res.data)
);

// ===== verif/longest_prefix_route_table_unit_test.sv =====
`timescale 1ns / 100ps

module longest_prefix_route_table_unit_test;

    localparam int unsigned CycleLimit = 30_000_000;
    localparam int unsigned PhaseItems = 250;

    logic i_clk;
    logic i_rst_n;

    lprt_op_if  i_op ();
    lprt_res_if o_res ();
    lprt_cfg_if i_cfg ();

    longest_prefix_route_table_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (i_op),
        .o_res   (o_res),
        .i_cfg   (i_cfg)
    );

    // Clock: 20 ns period.
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Shadow of the route table and of the two prefix bound registers.
    logic        rt_valid [lprt_pkg::TableEntries];
    logic [31:0] rt_dest  [lprt_pkg::TableEntries];
    logic [5:0]  rt_plen  [lprt_pkg::TableEntries];
    logic [31:0] rt_gw    [lprt_pkg::TableEntries];
    logic [5:0]  bound_min;
    logic [5:0]  bound_max;

    lprt_pkg::t_op     ops_pending [$];
    lprt_pkg::t_result routes_expected [$];
    int unsigned errors;
    int unsigned cycles;
    logic calm;

    // Pool of well-formed routes and next hops, so adds collide, fill the
    // table and deletes actually find something.
    logic [31:0] pool_dest [96];
    logic [5:0]  pool_plen [96];
    logic [31:0] hop_set   [8];

    function automatic logic [31:0] prefix_mask(input logic [5:0] p);
        if (p == 6'd0) return 32'd0;
        if (p >= 6'd32) return 32'hFFFF_FFFF;
        return 32'hFFFF_FFFF << (6'd32 - p);
    endfunction

    // Apply one operation to the shadow table and queue its outcome.
    task automatic route_apply(input lprt_pkg::t_op op);
        lprt_pkg::t_result r;
        int best;
        int same;
        int free_slot;
        int unsigned removed;
        logic [5:0] hi;
        logic [5:0] p;
        logic [31:0] key;
        logic matched;
        r.status = lprt_pkg::ST_OK;
        r.hit = 1'b0;
        r.next_hop = 32'hFFFF_FFFF;
        removed = 0;
        case (op.mode)
            lprt_pkg::MODE_LOOKUP: begin
                hi = (bound_max > 6'd32) ? 6'd32 : bound_max;
                if (bound_min <= hi) begin
                    p = hi;
                    // Walk lengths longest first; stop at the first winner.
                    forever begin
                        key = op.address & prefix_mask(p);
                        best = -1;
                        for (int i = 0; i < lprt_pkg::TableEntries; i++) begin
                            if (rt_valid[i] && rt_dest[i] == key && rt_plen[i] <= p &&
                                (best < 0 || rt_plen[i] > rt_plen[best]))
                                best = i;
                        end
                        if (best >= 0) begin
                            r.hit = 1'b1;
                            r.next_hop = rt_gw[best];
                            break;
                        end
                        if (p == bound_min) break;
                        p = p - 6'd1;
                    end
                end
            end
            lprt_pkg::MODE_ADD: begin
                if (op.prefix_len > 6'd32 || op.prefix_len < bound_min ||
                    op.prefix_len > bound_max) begin
                    r.status = lprt_pkg::ST_BAD_PREFIX;
                end else if (op.address == 32'hFFFF_FFFF) begin
                    r.status = lprt_pkg::ST_BAD_ADDRESS;
                end else if (op.gateway == 32'd0 || op.gateway == 32'hFFFF_FFFF) begin
                    r.status = lprt_pkg::ST_BAD_GATEWAY;
                end else if ((op.address & prefix_mask(op.prefix_len)) != op.address) begin
                    r.status = lprt_pkg::ST_BAD_ADDRESS;
                end else begin
                    same = -1;
                    free_slot = -1;
                    for (int i = 0; i < lprt_pkg::TableEntries; i++) begin
                        if (rt_valid[i]) begin
                            if (same < 0 && rt_dest[i] == op.address &&
                                rt_plen[i] == op.prefix_len)
                                same = i;
                        end else if (free_slot < 0) begin
                            free_slot = i;
                        end
                    end
                    if (same >= 0) begin
                        rt_gw[same] = op.gateway;
                    end else if (free_slot >= 0) begin
                        rt_valid[free_slot] = 1'b1;
                        rt_dest[free_slot] = op.address;
                        rt_plen[free_slot] = op.prefix_len;
                        rt_gw[free_slot] = op.gateway;
                    end else begin
                        r.status = lprt_pkg::ST_FULL;
                    end
                end
            end
            lprt_pkg::MODE_DEL_DEST, lprt_pkg::MODE_DEL_GW, lprt_pkg::MODE_DEL_EXACT: begin
                for (int i = 0; i < lprt_pkg::TableEntries; i++) begin
                    if (rt_valid[i] && rt_dest[i] == op.address) begin
                        if (op.mode == lprt_pkg::MODE_DEL_DEST)
                            matched = 1'b1;
                        else if (op.mode == lprt_pkg::MODE_DEL_GW)
                            matched = (rt_gw[i] == op.gateway);
                        else
                            matched = (rt_gw[i] == op.gateway && rt_plen[i] == op.prefix_len);
                        if (matched) begin
                            rt_valid[i] = 1'b0;
                            removed++;
                        end
                    end
                end
                if (removed == 0) r.status = lprt_pkg::ST_NOT_FOUND;
            end
            lprt_pkg::MODE_CLEAR: begin
                for (int i = 0; i < lprt_pkg::TableEntries; i++) rt_valid[i] = 1'b0;
            end
            default: ;
        endcase
        r.removed_count = (removed > 127) ? 7'd127 : removed[6:0];
        routes_expected.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    // Driver: hold an operation until transferred, then advance the queue.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_op.valid <= 1'b0;
        end else begin
            if (i_op.valid && i_op.ready) route_apply(i_op.data);
            if (!i_op.valid || i_op.ready) begin
                if (ops_pending.size() > 0 && (calm || $urandom_range(99) >= 20)) begin
                    i_op.valid <= 1'b1;
                    i_op.data <= ops_pending.pop_front();
                end else begin
                    i_op.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stall at random, check every transfer against the oldest expectation.
    always @(posedge i_clk) begin
        lprt_pkg::t_result want;
        if (!i_rst_n) begin
            o_res.ready <= 1'b0;
        end else begin
            if (o_res.valid && o_res.ready) begin
                if (routes_expected.size() == 0) begin
                    report_mismatch("unexpected result", o_res.data.next_hop, 32'd0);
                end else begin
                    want = routes_expected.pop_front();
                    if (o_res.data.status !== want.status)
                        report_mismatch("status", 32'(o_res.data.status),
                                        32'(want.status));
                    if (o_res.data.hit !== want.hit)
                        report_mismatch("hit", 32'(o_res.data.hit), 32'(want.hit));
                    if (o_res.data.next_hop !== want.next_hop)
                        report_mismatch("next_hop", o_res.data.next_hop, want.next_hop);
                    if (o_res.data.removed_count !== want.removed_count)
                        report_mismatch("removed_count", 32'(o_res.data.removed_count),
                                        32'(want.removed_count));
                end
            end
            o_res.ready <= calm || ($urandom_range(99) >= 20);
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("FAIL longest_prefix_route_table_unit");
            $finish;
        end
    end

    function automatic lprt_pkg::t_op mk_op(input logic [2:0] m, input logic [31:0] a,
                                            input logic [5:0] p, input logic [31:0] g);
        lprt_pkg::t_op op;
        op.mode = m;
        op.address = a;
        op.prefix_len = p;
        op.gateway = g;
        return op;
    endfunction

    // Mostly well-formed operations on the pool, with some noise.
    function automatic lprt_pkg::t_op random_op();
        int unsigned r;
        int unsigned k;
        logic [31:0] g;
        r = $urandom_range(99);
        k = $urandom_range(95);
        g = hop_set[$urandom_range(7)];
        if (r < 25)
            return mk_op(lprt_pkg::MODE_LOOKUP,
                         pool_dest[k] | ($urandom & ~prefix_mask(pool_plen[k])),
                         6'($urandom), $urandom);
        if (r < 32)
            return mk_op(lprt_pkg::MODE_LOOKUP, $urandom, 6'($urandom), $urandom);
        if (r < 58)
            return mk_op(lprt_pkg::MODE_ADD, pool_dest[k], pool_plen[k], g);
        if (r < 64) begin
            case ($urandom_range(3))
                0: g = 32'd0;
                1: g = 32'hFFFF_FFFF;
                default: g = $urandom;
            endcase
            return mk_op(lprt_pkg::MODE_ADD,
                         ($urandom_range(3) == 0) ? 32'hFFFF_FFFF : $urandom,
                         6'($urandom), g);
        end
        if (r < 73)
            return mk_op(lprt_pkg::MODE_DEL_DEST, pool_dest[k], 6'($urandom), $urandom);
        if (r < 82) return mk_op(lprt_pkg::MODE_DEL_GW, pool_dest[k], 6'($urandom), g);
        if (r < 91) return mk_op(lprt_pkg::MODE_DEL_EXACT, pool_dest[k], pool_plen[k], g);
        if (r < 94) return mk_op(lprt_pkg::MODE_DEL_DEST, $urandom, 6'($urandom), $urandom);
        if (r < 95) return mk_op(lprt_pkg::MODE_CLEAR, $urandom, 6'($urandom), $urandom);
        return mk_op(3'($urandom_range(7, 6)), $urandom, 6'($urandom), $urandom);
    endfunction

    task automatic drain();
        while (ops_pending.size() > 0 || i_op.valid || routes_expected.size() > 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Write one bound register; only called with the block idle.
    task automatic write_bound(input logic idx, input logic [5:0] val);
        @(posedge i_clk);
        i_cfg.valid <= 1'b1;
        i_cfg.index <= idx;
        i_cfg.wdata <= val;
        do @(posedge i_clk); while (!i_cfg.ready);
        if (idx == lprt_pkg::REG_MIN_PREFIX) bound_min = val;
        else bound_max = val;
        i_cfg.valid <= 1'b0;
    endtask

    task automatic random_phase(input logic [5:0] lo, input logic [5:0] hi);
        write_bound(lprt_pkg::REG_MIN_PREFIX, lo);
        write_bound(lprt_pkg::REG_MAX_PREFIX, hi);
        repeat (PhaseItems) ops_pending.push_back(random_op());
        drain();
    endtask

    initial begin
        logic [5:0] p;
        i_op.valid = 1'b0;
        i_op.data = '0;
        o_res.ready = 1'b0;
        i_cfg.valid = 1'b0;
        i_cfg.index = lprt_pkg::REG_MIN_PREFIX;
        i_cfg.wdata = '0;
        errors = 0;
        cycles = 0;
        calm = 1'b0;
        bound_min = 6'd0;
        bound_max = 6'd32;
        for (int i = 0; i < lprt_pkg::TableEntries; i++) rt_valid[i] = 1'b0;
        for (int i = 0; i < 8; i++) hop_set[i] = 32'h0A00_0001 + ($urandom & 32'h00FF_FF00);
        for (int i = 0; i < 96; i++) begin
            p = (i < 4) ? 6'(i * 8 + 8 * (i / 3)) : 6'($urandom_range(32));
            pool_plen[i] = p;
            pool_dest[i] = $urandom & prefix_mask(p);
            if (pool_dest[i] == 32'hFFFF_FFFF) pool_dest[i] = 32'h0;
        end
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, every operation, every rejection but a full table.
        ops_pending.push_back(mk_op(lprt_pkg::MODE_LOOKUP, 32'h0, 6'd0, 32'h0));
        ops_pending.push_back(mk_op(lprt_pkg::MODE_ADD, 32'h0, 6'd0, 32'hC0A8_0001));
        ops_pending.push_back(mk_op(lprt_pkg::MODE_ADD, 32'hFFFF_FFFE, 6'd32, 32'h0000_0001));
        ops_pending.push_back(mk_op(lprt_pkg::MODE_ADD, 32'h0A00_0000, 6'd8, 32'hFFFF_FFFE));
        ops_pending.push_back(mk_op(lprt_pkg::MODE_ADD, 32'h0A01_0000, 6'd16, 32'h0102_0304));
        ops_pending.push_back(mk_op(lprt_pkg::MODE_LOOKUP, 32'h0A01_0203, 6'd0, 32'h0));
        ops_pending.push_back(mk_op(lprt_pkg::MODE_LOOKUP, 32'h0A02_0203, 6'd0, 32'h0));
        ops_pending.push_back(mk_op(lprt_pkg::MODE_LOOKUP, 32'hFFFF_FFFE, 6'd0, 32'h0));
        ops_pending.push_back(mk_op(lprt_pkg::MODE_LOOKUP, 32'hFFFF_FFFF, 6'd63,
                                    32'hFFFF_FFFF));
        ops_pending.push_back(mk_op(lprt_pkg::MODE_ADD, 32'h0A00_0000, 6'd8, 32'h0505_0505));
        ops_pending.push_back(mk_op(lprt_pkg::MODE_ADD, 32'h0B00_0000, 6'd33, 32'h0505_0505));
        ops_pending.push_back(mk_op(lprt_pkg::MODE_ADD, 32'h0B00_0000, 6'd63, 32'h0505_0505));
        ops_pending.push_back(mk_op(lprt_pkg::MODE_ADD, 32'hFFFF_FFFF, 6'd32, 32'h0505_0505));
        ops_pending.push_back(mk_op(lprt_pkg::MODE_ADD, 32'h0B00_0000, 6'd8, 32'h0));
        ops_pending.push_back(mk_op(lprt_pkg::MODE_ADD, 32'h0B00_0000, 6'd8, 32'hFFFF_FFFF));
        ops_pending.push_back(mk_op(lprt_pkg::MODE_ADD, 32'h0B00_0001, 6'd8, 32'h0505_0505));
        ops_pending.push_back(mk_op(lprt_pkg::MODE_DEL_GW, 32'h0A01_0000, 6'd0,
                                    32'h0909_0909));
        ops_pending.push_back(mk_op(lprt_pkg::MODE_DEL_EXACT, 32'h0A00_0000, 6'd9,
                                    32'h0505_0505));
        ops_pending.push_back(mk_op(lprt_pkg::MODE_DEL_EXACT, 32'h0A00_0000, 6'd8,
                                    32'h0505_0505));
        ops_pending.push_back(mk_op(lprt_pkg::MODE_DEL_GW, 32'h0A01_0000, 6'd0,
                                    32'h0102_0304));
        ops_pending.push_back(mk_op(lprt_pkg::MODE_DEL_DEST, 32'h0, 6'd0, 32'h0));
        ops_pending.push_back(mk_op(lprt_pkg::MODE_DEL_DEST, 32'h0, 6'd0, 32'h0));
        ops_pending.push_back(mk_op(lprt_pkg::MODE_CLEAR, 32'hFFFF_FFFF, 6'd63,
                                    32'hFFFF_FFFF));
        ops_pending.push_back(mk_op(3'd6, 32'h0, 6'd0, 32'h0));
        ops_pending.push_back(mk_op(3'd7, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF));
        drain();

        // Random phases across bound settings, extremes among them.
        random_phase(6'd0, 6'd32);
        random_phase(6'd8, 6'd24);
        calm = 1'b1;
        random_phase(6'd0, 6'd63);
        calm = 1'b0;
        random_phase(6'd32, 6'd32);
        random_phase(6'd0, 6'd0);
        random_phase(6'd20, 6'd10);
        random_phase(6'd0, 6'd32);

        if (errors == 0) begin
            $display("PASS longest_prefix_route_table_unit");
        end else begin
            $display("FAIL longest_prefix_route_table_unit");
        end
        $finish;
    end

endmodule

// ===== longest_prefix_route_table_unit.f =====
rtl/lprt_pkg.sv
rtl/lprt_if.sv
rtl/lprt_cell.sv
rtl/longest_prefix_route_table_unit.sv
rtl/lprt_checker.sv
verif/longest_prefix_route_table_unit_test.sv
